### hw/rtl/pstn_pkg.sv
// pstn_pkg: shared constants, types and helpers of the five-point stencil sum block
// used by every rtl file of the block and by its checker

package pstn_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int PIXEL_BITS    = 16;
	localparam int COL_BITS      = $clog2(MAX_WIDTH);
	localparam int ROW_BITS      = 16;
	localparam int WCFG_BITS     = COL_BITS + 1;
	localparam int SUM_BITS      = PIXEL_BITS + 3;
	localparam int OUT_DATA_BITS = ((ROW_BITS + COL_BITS + SUM_BITS + 7) / 8) * 8;
	localparam int PADDR_BITS    = 3;
	localparam int APB_DATA_BITS = 32;

	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef logic signed [PIXEL_BITS-1:0] pixel_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                last_row;
		logic                last_col;
		pixel_t              px;
	} item_t;

	typedef struct packed {
		logic                done;
		sum_t                sum;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
	} result_t;

	typedef struct packed {
		logic [2:0]        valid;
		result_t [2:0]     data;
	} res_set_t;

	typedef struct packed {
		logic                en;
		logic [COL_BITS-1:0] addr;
		pixel_t              data;
	} up_wr_t;

	typedef struct packed {
		pixel_t mid_c;
		pixel_t mid_c1;
		pixel_t up_c;
	} line_rd_t;

	function automatic sum_t sext(input pixel_t v);
		return {{(SUM_BITS-PIXEL_BITS){v[PIXEL_BITS-1]}}, v};
	endfunction

endpackage

### hw/rtl/pstn_line_store.sv
// pstn_line_store: the two line memories (previous row and the row before it)
// depends on pstn_pkg; synchronous reads, bypass on the upper line

module pstn_line_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [pstn_pkg::COL_BITS-1:0] rd_col,
	input  pstn_pkg::pixel_t              mid_wdata,
	input  pstn_pkg::up_wr_t              up_wr,
	output pstn_pkg::line_rd_t            rd
);

	pstn_pkg::pixel_t mid_mem [pstn_pkg::MAX_WIDTH];
	pstn_pkg::pixel_t up_mem  [pstn_pkg::MAX_WIDTH];

	logic [pstn_pkg::COL_BITS-1:0] rd_col_next;
	pstn_pkg::pixel_t              mid_c_s1;
	pstn_pkg::pixel_t              mid_c1_s1;
	pstn_pkg::pixel_t              up_c_s1;
	pstn_pkg::pixel_t              fwd_data_s1;
	logic                          fwd_s1;

	assign rd_col_next = rd_col + 1'b1;

	// middle line: read old values, write the new pixel in the same request
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_c_s1          <= mid_mem[rd_col];
			mid_c1_s1         <= mid_mem[rd_col_next];
			mid_mem[rd_col]   <= mid_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_c_s1 <= up_mem[rd_col];
		end
		if (up_wr.en) begin
			up_mem[up_wr.addr] <= up_wr.data;
		end
	end

	// upper line is written when the item advances, after its read; bypass when a write and a read of one column coincide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_s1 <= up_wr.en && (up_wr.addr == rd_col);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= up_wr.data;
		end
	end

	assign rd.mid_c  = mid_c_s1;
	assign rd.mid_c1 = mid_c1_s1;
	assign rd.up_c   = fwd_s1 ? fwd_data_s1 : up_c_s1;

endmodule

### hw/rtl/pstn_stencil.sv
// pstn_stencil: stage 1 of the block, forms up to three neighbour sums per pixel
// depends on pstn_pkg; fed by pstn_line_store, drains into pstn_result_fifo

module pstn_stencil (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_accept,
	input  pstn_pkg::item_t                    in_item,
	input  pstn_pkg::line_rd_t                 line,
	input  logic [pstn_pkg::FIFO_CNT_BITS-1:0] fifo_space,
	output logic                               in_ready,
	output logic                               adv,
	output pstn_pkg::res_set_t                 res,
	output pstn_pkg::up_wr_t                   up_wr
);

	pstn_pkg::item_t  item_s1;
	logic             valid_s1;
	pstn_pkg::pixel_t left_q;
	pstn_pkg::pixel_t prev_q;
	pstn_pkg::pixel_t prev2_q;

	logic       c_ge1, c_ge2, r_ge1, r_ge2;
	logic [1:0] n_res;

	assign c_ge1 = item_s1.col != '0;
	assign c_ge2 = item_s1.col > pstn_pkg::COL_BITS'(1);
	assign r_ge1 = item_s1.row != '0;
	assign r_ge2 = item_s1.row > pstn_pkg::ROW_BITS'(1);

	always_comb begin
		res.valid[0] = r_ge1;
		res.valid[1] = item_s1.last_row && c_ge1;
		res.valid[2] = item_s1.last_row && item_s1.last_col;

		// sum for the pixel one row up, now that its lower neighbour is here
		res.data[0].row  = item_s1.row - 1'b1;
		res.data[0].col  = item_s1.col;
		res.data[0].done = 1'b0;
		res.data[0].sum  = pstn_pkg::sext(line.mid_c) + pstn_pkg::sext(item_s1.px)
			+ (c_ge1 ? pstn_pkg::sext(left_q) : '0)
			+ (!item_s1.last_col ? pstn_pkg::sext(line.mid_c1) : '0)
			+ (r_ge2 ? pstn_pkg::sext(line.up_c) : '0);

		// last row: the pixel to the left is complete
		res.data[1].row  = item_s1.row;
		res.data[1].col  = item_s1.col - 1'b1;
		res.data[1].done = 1'b0;
		res.data[1].sum  = pstn_pkg::sext(prev_q) + pstn_pkg::sext(item_s1.px)
			+ (c_ge2 ? pstn_pkg::sext(prev2_q) : '0)
			+ (r_ge1 ? pstn_pkg::sext(left_q) : '0);

		// final pixel of the frame
		res.data[2].row  = item_s1.row;
		res.data[2].col  = item_s1.col;
		res.data[2].done = 1'b1;
		res.data[2].sum  = pstn_pkg::sext(item_s1.px)
			+ (c_ge1 ? pstn_pkg::sext(prev_q) : '0)
			+ (r_ge1 ? pstn_pkg::sext(line.mid_c) : '0);
	end

	assign n_res = {1'b0, res.valid[0]} + {1'b0, res.valid[1]} + {1'b0, res.valid[2]};
	assign adv = valid_s1 && ({1'b0, n_res} <= fifo_space);
	assign in_ready = !valid_s1 || adv;

	assign up_wr.en   = adv;
	assign up_wr.addr = item_s1.col;
	assign up_wr.data = line.mid_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
		end
	end

	// previous row at column c-1, and this row at c-1 and c-2
	always_ff @(posedge clk) begin
		if (adv) begin
			left_q  <= line.mid_c;
			prev_q  <= item_s1.px;
			prev2_q <= prev_q;
		end
	end

endmodule

### hw/rtl/pstn_result_fifo.sv
// pstn_result_fifo: small result queue that takes up to three results at once
// depends on pstn_pkg; its head is the registered output of the block

module pstn_result_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  pstn_pkg::res_set_t                 push_set,
	output logic [pstn_pkg::FIFO_CNT_BITS-1:0] space,
	output logic                               out_valid,
	input  logic                               out_ready,
	output pstn_pkg::result_t                  out_data
);

	pstn_pkg::result_t mem [pstn_pkg::FIFO_DEPTH];

	logic [pstn_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [pstn_pkg::FIFO_CNT_BITS-1:0] count_q;
	logic [pstn_pkg::FIFO_PTR_BITS-1:0] wr_idx [3];
	logic [pstn_pkg::FIFO_PTR_BITS-1:0] n_push;
	logic                               pop;

	// pack the valid results of one request into consecutive slots
	always_comb begin
		wr_idx[0] = wr_ptr_q;
		wr_idx[1] = wr_ptr_q + pstn_pkg::FIFO_PTR_BITS'(push_set.valid[0]);
		wr_idx[2] = wr_idx[1] + pstn_pkg::FIFO_PTR_BITS'(push_set.valid[1]);
		n_push = push ? (pstn_pkg::FIFO_PTR_BITS'(push_set.valid[0])
			+ pstn_pkg::FIFO_PTR_BITS'(push_set.valid[1])
			+ pstn_pkg::FIFO_PTR_BITS'(push_set.valid[2])) : '0;
	end

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rd_ptr_q];
	assign space     = pstn_pkg::FIFO_CNT_BITS'(pstn_pkg::FIFO_DEPTH) - count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (push && push_set.valid[i]) begin
				mem[wr_idx[i]] <= push_set.data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + pstn_pkg::FIFO_PTR_BITS'(pop);
			count_q  <= count_q + pstn_pkg::FIFO_CNT_BITS'(n_push)
				- pstn_pkg::FIFO_CNT_BITS'(pop);
		end
	end

endmodule

### hw/rtl/plus_stencil_neighbour_sum.sv
// plus_stencil_neighbour_sum: top level with configuration registers and raster counters
// depends on pstn_pkg, pstn_line_store, pstn_stencil and pstn_result_fifo

// Sums each pixel of a raster-order frame with its up, down, left and right
// neighbours (outside the frame they count as zero) and returns row, column and
// sum. One pixel is taken per cycle while the result queue has room; the result
// for row r goes out while row r+1 streams in. On the last row a pixel may
// complete two or three results; with one result leaving per cycle while the
// receiver is ready, the single output port paces the last row. The two line
// stores are 1024 x 16 bit memories with synchronous reads and need no
// clearing after reset. Write frame_width (byte address 0) and frame_height
// (address 4) only while the block is idle; a write restarts the frame at row 0.

module plus_stencil_neighbour_sum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pstn_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [pstn_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [pstn_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [pstn_pkg::PIXEL_BITS-1:0]      s_tdata,  // pixel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [pstn_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // out_row, out_col, neighbour_sum, zero pad
	output logic                                 m_tlast   // frame_done
);

	logic [pstn_pkg::WCFG_BITS-1:0] frame_width_q;
	logic [pstn_pkg::ROW_BITS-1:0]  frame_height_q;
	logic [pstn_pkg::COL_BITS-1:0]  col_q;
	logic [pstn_pkg::ROW_BITS-1:0]  row_q;
	logic [pstn_pkg::COL_BITS-1:0]  col_max;
	logic [pstn_pkg::ROW_BITS-1:0]  row_max;
	logic                           cfg_wr;
	logic                           in_accept;
	logic                           in_ready;
	logic                           adv;
	logic [pstn_pkg::FIFO_CNT_BITS-1:0] fifo_space;

	pstn_pkg::item_t    item;
	pstn_pkg::line_rd_t line;
	pstn_pkg::up_wr_t   up_wr;
	pstn_pkg::res_set_t res;
	pstn_pkg::result_t  out_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pstn_pkg::WCFG_BITS'(pstn_pkg::MAX_WIDTH);
			frame_height_q <= pstn_pkg::ROW_BITS'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				pstn_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= pwdata[pstn_pkg::WCFG_BITS-1:0];
				end
				pstn_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[pstn_pkg::ROW_BITS-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pstn_pkg::REG_FRAME_WIDTH: begin
				prdata = pstn_pkg::APB_DATA_BITS'(frame_width_q);
			end
			pstn_pkg::REG_FRAME_HEIGHT: begin
				prdata = pstn_pkg::APB_DATA_BITS'(frame_height_q);
			end
		endcase
	end

	// zero width acts as one, oversize width as the line store depth
	always_comb begin
		priority if (frame_width_q == '0) begin
			col_max = '0;
		end else if (frame_width_q > pstn_pkg::WCFG_BITS'(pstn_pkg::MAX_WIDTH)) begin
			col_max = pstn_pkg::COL_BITS'(pstn_pkg::MAX_WIDTH - 1);
		end else begin
			col_max = pstn_pkg::COL_BITS'(frame_width_q - 1'b1);
		end
		row_max = (frame_height_q == '0) ? '0 : frame_height_q - 1'b1;
	end

	assign s_tready  = in_ready;
	assign in_accept = s_tvalid && s_tready;

	always_comb begin
		item.row      = row_q;
		item.col      = col_q;
		item.last_row = row_q == row_max;
		item.last_col = col_q == col_max;
		item.px       = s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (item.last_col) begin
				col_q <= '0;
				row_q <= item.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	pstn_line_store u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_accept),
		.rd_col    (col_q),
		.mid_wdata (s_tdata),
		.up_wr     (up_wr),
		.rd        (line)
	);

	pstn_stencil u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.in_item    (item),
		.line       (line),
		.fifo_space (fifo_space),
		.in_ready   (in_ready),
		.adv        (adv),
		.res        (res),
		.up_wr      (up_wr)
	);

	pstn_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.push_set  (res),
		.space     (fifo_space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = pstn_pkg::OUT_DATA_BITS'({out_res.sum, out_res.col, out_res.row});
	assign m_tlast = out_res.done;

endmodule

### hw/rtl/pstn_checker.sv
// pstn_checker: port-level assertions for plus_stencil_neighbour_sum, bound to the top
// depends on pstn_pkg; tracks the frame size from configuration writes

module pstn_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 psel,
	input logic                                 penable,
	input logic                                 pwrite,
	input logic [pstn_pkg::PADDR_BITS-1:0]      paddr,
	input logic [pstn_pkg::APB_DATA_BITS-1:0]   pwdata,
	input logic                                 pready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [pstn_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input logic                                 m_tlast
);

	logic [pstn_pkg::COL_BITS-1:0]  col_max_q;
	logic [pstn_pkg::ROW_BITS-1:0]  row_max_q;
	logic [pstn_pkg::WCFG_BITS-1:0] wr_width;
	logic [pstn_pkg::ROW_BITS-1:0]  wr_height;
	logic [pstn_pkg::ROW_BITS-1:0]  o_row;
	logic [pstn_pkg::COL_BITS-1:0]  o_col;

	assign wr_width  = pwdata[pstn_pkg::WCFG_BITS-1:0];
	assign wr_height = pwdata[pstn_pkg::ROW_BITS-1:0];
	assign o_row     = m_tdata[pstn_pkg::ROW_BITS-1:0];
	assign o_col     = m_tdata[pstn_pkg::ROW_BITS +: pstn_pkg::COL_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_max_q <= pstn_pkg::COL_BITS'(pstn_pkg::MAX_WIDTH - 1);
			row_max_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == pstn_pkg::REG_FRAME_WIDTH) begin
				if (wr_width == '0) begin
					col_max_q <= '0;
				end else if (wr_width > pstn_pkg::WCFG_BITS'(pstn_pkg::MAX_WIDTH)) begin
					col_max_q <= pstn_pkg::COL_BITS'(pstn_pkg::MAX_WIDTH - 1);
				end else begin
					col_max_q <= pstn_pkg::COL_BITS'(wr_width - 1'b1);
				end
			end else begin
				row_max_q <= (wr_height == '0) ? '0 : wr_height - 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_done_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> o_col == col_max_q && o_row == row_max_q)
		else $error("frame end flagged away from the last pixel");

	a_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o_col <= col_max_q && o_row <= row_max_q)
		else $error("result position outside the frame");

endmodule

bind plus_stencil_neighbour_sum pstn_checker u_pstn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### tb/plus_stencil_neighbour_sum_tb.sv
// plus_stencil_neighbour_sum_tb: self-checking bench for the five-point stencil sum block
// drives pixel frames and apb register writes, predicts every neighbour sum and compares
// depends on pstn_pkg and plus_stencil_neighbour_sum

module plus_stencil_neighbour_sum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pstn_pkg::*;

	localparam int LIMIT_CYCLES    = 500000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int PRESSURE_CYCLES = 300;
	localparam int PHASE_PIXELS    = 80;
	localparam int SAT_PIXELS      = 24;
	localparam int REPORT_LIMIT    = 10;
	localparam pixel_t PIX_MAX     = 16'sh7fff;
	localparam pixel_t PIX_MIN     = 16'sh8000;

	typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;
	typedef enum int {FILL_NOISE, FILL_FLAT, FILL_SMALL, FILL_RAILS} fill_t;

	typedef struct {
		step_kind_t kind;
		logic       reg_sel;
		int         value;
		bit         typed;
		int         typed_sum;
	} step_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     psel     = 1'b0;
	logic                     penable  = 1'b0;
	logic                     pwrite   = 1'b0;
	logic [PADDR_BITS-1:0]    paddr    = '0;
	logic [APB_DATA_BITS-1:0] pwdata   = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [PIXEL_BITS-1:0]    s_tdata  = '0;   // pixel
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;         // out_row, out_col, neighbour_sum, zero pad
	logic                     m_tlast;         // frame_done

	// predictor state: two line stores, raster position, previous pixel, registers
	int                   upper_row [MAX_WIDTH];
	int                   middle_row [MAX_WIDTH];
	int                   col_pos    = 0;
	int                   row_pos    = 0;
	int                   last_px    = 0;
	logic [WCFG_BITS-1:0] width_reg  = WCFG_BITS'(MAX_WIDTH);
	logic [ROW_BITS-1:0]  height_reg = ROW_BITS'(1);
	result_t              pending_sums [$];

	int idle_pct     = 0;
	int stall_pct    = 0;
	int hold_left    = 0;
	int pixels_sent  = 0;
	int sums_checked = 0;
	int regs_written = 0;
	int mismatches   = 0;
	int cycle_count  = 0;

	plus_stencil_neighbour_sum i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	function automatic void flag_error(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) $display("%s", msg);
	endfunction

	function automatic void queue_sum(input int r, input int c, input int s, input bit done);
		result_t e;
		e.row  = r[ROW_BITS-1:0];
		e.col  = c[COL_BITS-1:0];
		e.sum  = s[SUM_BITS-1:0];
		e.done = done;
		pending_sums.push_back(e);
	endfunction

	// works out the sums completed by one accepted pixel, 0 to 3 of them
	function automatic void stencil_predict(input pixel_t px);
		int w, h, r, c, s, p, mid_old, up_old, rgt, lft;
		bit last_r, last_c;
		p = px;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
		h = (height_reg == 0) ? 1 : int'(height_reg);
		r = (row_pos >= h) ? h - 1 : row_pos;
		c = (col_pos >= w) ? w - 1 : col_pos;
		last_r = (r == h - 1);
		last_c = (c == w - 1);
		mid_old = middle_row[c];
		up_old  = upper_row[c];
		rgt = (c + 1 < w) ? middle_row[c + 1] : 0;
		lft = (c >= 1) ? upper_row[c - 1] : 0;
		upper_row[c]  = mid_old;
		middle_row[c] = p;
		// pixel below completes the sum of the row above
		if (r >= 1) begin
			s = mid_old + p + lft + rgt;
			if (r >= 2) s += up_old;
			queue_sum(r - 1, c, s, 1'b0);
		end
		// last row trails by one pixel
		if (last_r && c >= 1) begin
			s = last_px + p;
			if (c >= 2) s += middle_row[c - 2];
			if (r >= 1) s += upper_row[c - 1];
			queue_sum(r, c - 1, s, 1'b0);
		end
		if (last_r && last_c) begin
			s = p;
			if (c >= 1) s += last_px;
			if (r >= 1) s += mid_old;
			queue_sum(r, c, s, 1'b1);
		end
		last_px = p;
		if (last_c) begin
			col_pos = 0;
			row_pos = last_r ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic pixel_t pick_pixel(input fill_t fill, input pixel_t flat);
		case (fill)
			FILL_FLAT:  return flat;
			FILL_SMALL: return pixel_t'(int'($urandom_range(16)) - 8);
			FILL_RAILS: return $urandom_range(1) ? PIX_MAX : PIX_MIN;
			default:    return pixel_t'($urandom());
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_pixel(input pixel_t px, input bit typed = 1'b0, input int typed_sum = 0);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		stencil_predict(px);
		// one-pixel frame: the sum is known by hand
		if (typed) begin
			void'(pending_sums.pop_back());
			queue_sum(0, 0, typed_sum, 1'b1);
		end
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write one register, read it back, then restart the predicted frame
	task automatic write_reg(input logic sel, input int value);
		logic [APB_DATA_BITS-1:0] readback;
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = '0;
		if (sel == REG_FRAME_WIDTH) begin
			width_reg = value[WCFG_BITS-1:0];
			readback[WCFG_BITS-1:0] = width_reg;
		end else begin
			height_reg = value[ROW_BITS-1:0];
			readback[ROW_BITS-1:0] = height_reg;
		end
		if (prdata !== readback)
			flag_error($sformatf("register %0d read back %0h, expected %0h",
				sel, prdata, readback));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		col_pos = 0;
		row_pos = 0;
		regs_written++;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row  = m_tdata[ROW_BITS-1:0];
			got.col  = m_tdata[ROW_BITS +: COL_BITS];
			got.sum  = m_tdata[ROW_BITS+COL_BITS +: SUM_BITS];
			got.done = m_tlast;
			if (pending_sums.size() == 0) begin
				flag_error($sformatf("unexpected sum: row %0d col %0d sum %0d last %0b",
					got.row, got.col, got.sum, got.done));
			end else begin
				want = pending_sums.pop_front();
				if (got.row !== want.row || got.col !== want.col ||
						got.sum !== want.sum || got.done !== want.done)
					flag_error($sformatf({"sum mismatch: expected row %0d col %0d sum %0d ",
						"last %0b, got row %0d col %0d sum %0d last %0b"},
						want.row, want.col, want.sum, want.done,
						got.row, got.col, got.sum, got.done));
				sums_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d sums outstanding",
				cycle_count, pending_sums.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		step_t  plan [];
		int     w, h, frames, len, k, phase_px;
		fill_t  fill;
		pixel_t flat;

		plan = '{
			// reset setting: one row of 1024, cut short by the next write
			'{STEP_PIX, REG_FRAME_WIDTH, 5, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -7, 1'b0, 0},
			// single pixel frames at the rails
			'{STEP_CFG, REG_FRAME_WIDTH, 1, 1'b0, 0},
			'{STEP_CFG, REG_FRAME_HEIGHT, 1, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b1, 32767},
			'{STEP_PIX, REG_FRAME_WIDTH, -32768, 1'b1, -32768},
			// zero width and zero height both act as one
			'{STEP_CFG, REG_FRAME_WIDTH, 0, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 1234, 1'b1, 1234},
			'{STEP_CFG, REG_FRAME_HEIGHT, 0, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -5, 1'b1, -5},
			// single row
			'{STEP_CFG, REG_FRAME_WIDTH, 3, 1'b0, 0},
			'{STEP_CFG, REG_FRAME_HEIGHT, 1, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			// single column
			'{STEP_CFG, REG_FRAME_WIDTH, 1, 1'b0, 0},
			'{STEP_CFG, REG_FRAME_HEIGHT, 3, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -32768, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -32768, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -32768, 1'b0, 0},
			// 3x3 at the top rail, centre reaches the largest sum
			'{STEP_CFG, REG_FRAME_WIDTH, 3, 1'b0, 0},
			'{STEP_CFG, REG_FRAME_HEIGHT, 3, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 32767, 1'b0, 0},
			// tallest frame, only its top rows are streamed
			'{STEP_CFG, REG_FRAME_WIDTH, 1, 1'b0, 0},
			'{STEP_CFG, REG_FRAME_HEIGHT, 65535, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 100, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -200, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, 300, 1'b0, 0},
			'{STEP_PIX, REG_FRAME_WIDTH, -400, 1'b0, 0}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG)
				write_reg(plan[i].reg_sel, plan[i].value);
			else
				send_pixel(pixel_t'(plan[i].value), plan[i].typed, plan[i].typed_sum);
		end

		// width above the line store size saturates, start of such a row
		write_reg(REG_FRAME_WIDTH, 2047);
		write_reg(REG_FRAME_HEIGHT, 1);
		repeat (SAT_PIXELS) send_pixel(pixel_t'($urandom()));

		for (int p = 0; p < 4; p++) begin
			idle_pct  = (p == 1) ? 78 : ((p == 3) ? 32 : 0);
			stall_pct = (p == 2) ? 78 : ((p == 3) ? 32 : 0);
			phase_px  = 0;
			while (phase_px < PHASE_PIXELS) begin
				w = ($urandom_range(7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				h = (w > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
				if (p == 0 && phase_px == 0) begin
					w = 8;
					h = 6;
				end
				write_reg(REG_FRAME_WIDTH, w);
				write_reg(REG_FRAME_HEIGHT, h);
				// long receiver hold while pixels keep coming, fills the block up
				if (p == 0 && phase_px == 0) hold_left = PRESSURE_CYCLES;
				frames = $urandom_range(1, 3);
				for (int f = 0; f < frames; f++) begin
					k    = $urandom_range(5);
					fill = (k < 3) ? FILL_NOISE : fill_t'(k - 2);
					flat = $urandom_range(1) ? PIX_MAX : PIX_MIN;
					len  = w * h;
					// a frame cut short is restarted by the next register write
					if (f == frames - 1 && $urandom_range(7) == 0) len = $urandom_range(1, len);
					// the phase ends at its pixel budget, mid-frame if need be
					if (len > PHASE_PIXELS - phase_px) len = PHASE_PIXELS - phase_px;
					repeat (len) begin
						send_pixel(pick_pixel(fill, flat));
						phase_px++;
					end
				end
			end
		end

		settle();
		$display("streamed %0d pixels and checked %0d sums across %0d register writes,",
			pixels_sent, sums_checked, regs_written);
		$display("with single pixel, row, column, saturated and stalled-output frames");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/pstn_pkg.sv
hw/rtl/pstn_line_store.sv
hw/rtl/pstn_stencil.sv
hw/rtl/pstn_result_fifo.sv
hw/rtl/plus_stencil_neighbour_sum.sv
hw/rtl/pstn_checker.sv
tb/plus_stencil_neighbour_sum_tb.sv
